// File: hw/rtl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OCC_W    = 5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // Command from the controller to the datapath for one accepted word.
    typedef struct packed {
        logic load;    // a word is accepted this cycle
        logic insert;  // place the new value in order
        logic pop;     // remove the head entry
    } spq_cmd_t;

endpackage

// File: hw/rtl/spq_datapath.sv
// Datapath of the sorted priority queue: ordered cell array and popped value register.
`timescale 1ns / 1ps

module spq_datapath
    import spq_pkg::*;
#(
    parameter int unsigned CAPACITY = 16,
    parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                      aclk,
    input  spq_cmd_t                  cmd,
    input  logic        [CNT_W-1:0]   count,
    input  logic signed [VALUE_W-1:0] new_value,
    output logic signed [VALUE_W-1:0] popped_value
);

    logic signed [VALUE_W-1:0] entries_reg [CAPACITY];
    logic signed [VALUE_W-1:0] entries_next [CAPACITY];
    logic signed [VALUE_W-1:0] popped_reg;
    logic signed [VALUE_W-1:0] popped_next;
    logic [CAPACITY-1:0]       greater;

    // Each cell flags whether the new value belongs at or before it. Cells at
    // or beyond the occupancy always flag, so the first flag marks the slot.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        always_comb begin
            greater[i] = (CNT_W'(i) >= count) || (entries_reg[i] > new_value);
        end

        always_comb begin
            entries_next[i] = entries_reg[i];
            if (cmd.insert) begin
                if (greater[i]) begin
                    if (i == 0) begin
                        entries_next[i] = new_value;
                    end else if (!greater[(i == 0) ? 0 : i - 1]) begin
                        entries_next[i] = new_value;
                    end else begin
                        entries_next[i] = entries_reg[(i == 0) ? 0 : i - 1];
                    end
                end
            end else if (cmd.pop) begin
                if (i < CAPACITY - 1) begin
                    entries_next[i] = entries_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end

        always_ff @(posedge aclk) begin
            entries_reg[i] <= entries_next[i];
        end
    end

    always_comb begin
        popped_next = popped_reg;
        if (cmd.load) begin
            popped_next = cmd.pop ? entries_reg[0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        popped_reg <= popped_next;
    end

    assign popped_value = popped_reg;

endmodule

// File: hw/rtl/spq_ctrl.sv
// Controller of the sorted priority queue: handshakes, occupancy and status.
`timescale 1ns / 1ps

module spq_ctrl
    import spq_pkg::*;
#(
    parameter int unsigned CAPACITY = 16,
    parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_opcode,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [OCC_W-1:0]    m_occupancy,
    output spq_cmd_t            cmd,
    output logic [CNT_W-1:0]    count
);

    typedef enum logic {
        OUT_IDLE,
        OUT_HOLD
    } out_state_t;

    out_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                accept;
    logic                is_full;
    logic                is_empty;

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign s_ready  = (state_reg == OUT_IDLE) || m_ready;
    assign accept   = s_valid && s_ready;

    always_comb begin
        cmd        = '0;
        cmd.load   = accept;
        cmd.insert = accept && (s_opcode == OP_INSERT) && !is_full;
        cmd.pop    = accept && (s_opcode == OP_POP) && !is_empty;
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        status_next = status_reg;
        if (accept) begin
            state_next = OUT_HOLD;
            if (s_opcode == OP_INSERT) begin
                status_next = is_full ? ST_FULL : ST_OK;
            end else begin
                status_next = is_empty ? ST_EMPTY : ST_OK;
            end
            if (cmd.insert) begin
                count_next = count_reg + 1'b1;
            end else if (cmd.pop) begin
                count_next = count_reg - 1'b1;
            end
        end else begin
            unique case (state_reg)
                OUT_IDLE: state_next = OUT_IDLE;
                OUT_HOLD: state_next = m_ready ? OUT_IDLE : OUT_HOLD;
                default:  state_next = OUT_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= OUT_IDLE;
            count_reg  <= '0;
            status_reg <= ST_OK;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    assign m_valid     = (state_reg == OUT_HOLD);
    assign m_status    = status_reg;
    assign m_occupancy = OCC_W'(count_reg);
    assign count       = count_reg;

endmodule

// File: hw/rtl/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue: controller and cell datapath.
`timescale 1ns / 1ps

// Channel  Ports                                       Word
// -------  ------------------------------------------  ---------------------------------
// input    s_valid, s_ready, s_opcode, s_value         opcode (insert/pop), signed value
// result   m_valid, m_ready, m_status,                 status, popped value, occupancy
//          m_popped_value, m_occupancy
//
// Every accepted word executes in its accept cycle: all cells compare against the new
// value in parallel and shift, so one word per cycle is sustained while m_ready is high.
// The result appears in an output register in the cycle after acceptance.
// aresetn is synchronous and active low; it empties the queue and drops any result.
// A stalled result blocks intake only while m_ready is low; when the result is
// taken a new word can be accepted in the same cycle.

module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_opcode,
    input  logic signed [VALUE_W-1:0] s_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [STATUS_W-1:0]       m_status,
    output logic signed [VALUE_W-1:0] m_popped_value,
    output logic [OCC_W-1:0]          m_occupancy
);

    // Occupancy counter must hold the capacity itself.
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    spq_cmd_t         cmd;
    logic [CNT_W-1:0] count;

    // The controller decides, from the occupancy, whether an insert or pop
    // really changes the queue, and keeps the status and occupancy outputs.
    spq_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_occupancy (m_occupancy),
        .cmd         (cmd),
        .count       (count)
    );

    // The datapath holds the sorted entries and registers the popped value.
    spq_datapath #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_datapath (
        .aclk         (aclk),
        .cmd          (cmd),
        .count        (count),
        .new_value    (s_value),
        .popped_value (m_popped_value)
    );

endmodule

// File: test/sorted_priority_queue_unit_tb.sv
// Self-checking testbench for the sorted priority queue: directed and random words, scoreboard.
`timescale 1ns / 1ps

module sorted_priority_queue_unit_tb;
    import spq_pkg::*;

    localparam int unsigned CAPACITY   = 16;
    localparam int unsigned PHASE_LEN  = 480;
    localparam int unsigned DRAIN_MAX  = 20000;
    localparam int unsigned MAX_REPORT = 50;

    // One expected result word.
    typedef struct {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] popped;
        logic [OCC_W-1:0]          occ;
    } queue_result_t;

    // Mirror of the queue contents plus the list of result words still owed by the block.
    class queue_mirror;
        logic signed [VALUE_W-1:0] slots [CAPACITY];
        int unsigned               held;
        queue_result_t             owed [$];
        int unsigned               fail_count;

        function new();
            held       = 0;
            fail_count = 0;
        endfunction

        function void report(string what);
            fail_count++;
            if (fail_count <= MAX_REPORT) begin
                $error("%s", what);
            end
        endfunction

        // Apply one accepted input word and record the result it must produce.
        function void note_word(logic op, logic signed [VALUE_W-1:0] val);
            queue_result_t r;
            int unsigned   pos;
            r.status = ST_OK;
            r.popped = '0;
            if (op == OP_INSERT) begin
                if (held >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    // New value goes behind every stored value not greater than it.
                    pos = 0;
                    while (pos < held && slots[pos] <= val) pos++;
                    for (int unsigned i = held; i > pos; i--) slots[i] = slots[i-1];
                    slots[pos] = val;
                    held++;
                end
            end else begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped = slots[0];
                    for (int unsigned i = 1; i < held; i++) slots[i-1] = slots[i];
                    held--;
                end
            end
            r.occ = held[OCC_W-1:0];
            owed.push_back(r);
        endfunction

        // Compare one result word taken from the block with the oldest owed word.
        function void check_word(logic [STATUS_W-1:0] st, logic signed [VALUE_W-1:0] pv,
                                 logic [OCC_W-1:0] occ);
            queue_result_t r;
            if (owed.size() == 0) begin
                report($sformatf("unexpected result word: status %0d popped_value %0d occupancy %0d",
                                 st, pv, occ));
                return;
            end
            r = owed.pop_front();
            if (st !== r.status)
                report($sformatf("status: expected %0d actual %0d", r.status, st));
            if (pv !== r.popped)
                report($sformatf("popped_value: expected %0d actual %0d", r.popped, pv));
            if (occ !== r.occ)
                report($sformatf("occupancy: expected %0d actual %0d", r.occ, occ));
        endfunction

        function int unsigned outstanding();
            return owed.size();
        endfunction
    endclass

    // Every input is known from time zero.
    logic                      aclk           = 1'b0;
    logic                      aresetn        = 1'b0;
    logic                      s_valid        = 1'b0;
    logic                      s_opcode       = OP_INSERT;
    logic signed [VALUE_W-1:0] s_value        = '0;
    logic                      m_ready        = 1'b0;
    logic                      s_ready;
    logic                      m_valid;
    logic [STATUS_W-1:0]       m_status;
    logic signed [VALUE_W-1:0] m_popped_value;
    logic [OCC_W-1:0]          m_occupancy;

    // Percent of cycles in which the sender idles and the receiver stalls.
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;

    queue_mirror mirror;

    sorted_priority_queue_unit #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_popped_value(m_popped_value),
        .m_occupancy   (m_occupancy)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Receiver: ready is redrawn at each falling edge from the current stall rate.
    always @(negedge aclk) begin
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Result monitor. Sampling at the rising edge sees the values from before the edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            mirror.check_word(m_status, m_popped_value, m_occupancy);
        end
    end

    // Offer one word and hold it until it is accepted. Called and returns at a falling edge.
    task automatic send_word(input logic op, input logic signed [VALUE_W-1:0] val);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_value  <= val;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        mirror.note_word(op, val);
        @(negedge aclk);
    endtask

    // Sender holds off until every owed result word has arrived or the DRAIN_MAX wait limit is reached.
    task automatic drain_results();
        int unsigned waited;
        waited  = 0;
        s_valid <= 1'b0;
        while (mirror.outstanding() != 0 && waited < DRAIN_MAX) begin
            @(negedge aclk);
            waited++;
        end
    endtask

    // Values lean toward a small pool so that equal keys and ties are common.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 40) return $urandom;
        if (k < 70) return $signed($urandom_range(8)) - 4;
        if (k < 85) begin
            case ($urandom_range(3))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        return $signed($urandom) >>> $urandom_range(31);
    endfunction

    // Random walk of inserts and pops. The insert bias changes every few dozen words so
    // the queue swings between empty and full, with pops and full inserts on both ends.
    task automatic random_phase(input int unsigned n_words, input bit mid_drain);
        int unsigned bias;
        logic        op;
        bias = 50;
        for (int unsigned i = 0; i < n_words; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(2))
                    0: bias = 15;
                    1: bias = 50;
                    default: bias = 85;
                endcase
            end
            if (mid_drain && i == n_words / 2) drain_results();
            op = ($urandom_range(99) < bias) ? OP_INSERT : OP_POP;
            send_word(op, pick_value());
        end
        drain_results();
    endtask

    // Directed start: pop on empty, extremes and ties, filling to capacity, an insert that
    // is dropped because the queue is full, then a few pops.
    task automatic directed_words();
        logic signed [VALUE_W-1:0] fill [16];
        fill = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1, 32'sd5, 32'sd5,
                 -32'sd5, 32'sd5, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd100, -32'sd100,
                 32'sd7, 32'sd3, 32'sh5555_AAAA};
        send_word(OP_POP, 32'sh7FFF_FFFF);
        foreach (fill[i]) send_word(OP_INSERT, fill[i]);
        send_word(OP_INSERT, 32'sd42);
        repeat (5) send_word(OP_POP, $urandom);
        drain_results();
    endtask

    initial begin
        int unsigned failures;
        mirror = new();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        directed_words();

        // No idling, then a busy-idle sender, then a stalling receiver, then both.
        idle_pct = 0;  stall_pct = 0;
        random_phase(PHASE_LEN, 1'b0);
        idle_pct = 62; stall_pct = 0;
        random_phase(PHASE_LEN, 1'b1);
        idle_pct = 0;  stall_pct = 62;
        random_phase(PHASE_LEN, 1'b0);
        idle_pct = 36; stall_pct = 36;
        random_phase(PHASE_LEN, 1'b1);

        // Let any stray result word show up before the verdict.
        repeat (8) @(posedge aclk);
        failures = mirror.fail_count;
        if (mirror.outstanding() != 0) begin
            $error("result words never arrived: %0d outstanding", mirror.outstanding());
            failures++;
        end
        if (failures == 0) begin
            $display("sorted_priority_queue_unit_tb: PASS");
        end else begin
            $display("sorted_priority_queue_unit_tb: FAIL");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("sorted_priority_queue_unit_tb: FAIL");
        $finish;
    end

endmodule
